// ===== rtl/core/hex_cell_dither_defines.svh =====
// ----------------------------------------------------------------------------
// hex_cell_dither_defines
// Assertion macros used by the hex cell dither top.
// ----------------------------------------------------------------------------
`ifndef HEX_CELL_DITHER_DEFINES_SVH
`define HEX_CELL_DITHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hex_cell_dither: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hex_cell_dither: next-cycle check failed");

`endif

// ===== rtl/core/hcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_pkg
// Constants, widths and types of the hex cell dither pipeline.
// ----------------------------------------------------------------------------
package hcd_pkg;

    // Position fields and default coordinate width
    localparam int POS_W          = 12;
    localparam int COORD_BITS_DEF = 12;

    // q = x * 65536 * 125 / 1732 = x * 2048000 / 433 = x * Q_MUL_INT + x * Q_MUL_FRAC / 433
    localparam int unsigned Q_NUM      = 2048000;
    localparam int unsigned Q_DIV      = 433;
    localparam int unsigned Q_MUL_INT  = Q_NUM / Q_DIV;
    localparam int unsigned Q_MUL_FRAC = Q_NUM % Q_DIV;
    localparam int          Q_RCP_SH   = 24;
    localparam int unsigned Q_RCP      = (32'd1 << Q_RCP_SH) / Q_DIV;

    // Datapath widths (positions are at most 12 bits wide)
    localparam int BASE_W = 25;   // x * Q_MUL_INT
    localparam int T_W    = 21;   // x * Q_MUL_FRAC
    localparam int QA_W   = 12;   // x * Q_MUL_FRAC / 433
    localparam int QF_W   = 25;   // q in Q16
    localparam int CW     = 27;   // signed q, r, s in Q16
    localparam int ERR_W  = 17;   // rounding error in Q16
    localparam int GAIN_W = 26;   // signed gain numerator
    localparam int P_W    = 18;   // channel * gain >> 15

    // Cell hash multipliers (only the low byte of the hash is consumed)
    localparam logic [31:0] HASH_MUL_Q = 32'd374761393;
    localparam logic [31:0] HASH_MUL_R = 32'd668265263;

    // Gain: numerator base 510 * 16384, denominator 255 * 2^15
    localparam int unsigned GAIN_BASE = 8355840;
    localparam int          GAIN_SH   = 15;
    localparam int unsigned CH_MAX    = 255;
    localparam int unsigned CH_CLAMP  = CH_MAX * 256;
    localparam int          D255_SH   = 24;
    localparam int unsigned D255_RCP  = (32'd1 << D255_SH) / CH_MAX;

    localparam logic [7:0]  ALPHA          = 8'hFF;
    localparam logic [15:0] STRENGTH_RESET = 16'd2458;

    // Pipeline depth: stages 0..8 in the top, 9..11 in the channel scalers
    localparam int NSTAGE = 12;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [7:0]       n8;
        logic [ERR_W-1:0] err;
    } t_round;

    // Advance enables for the three channel scaler stages
    typedef struct packed {
        logic adv_mul;
        logic adv_div;
        logic adv_out;
    } t_scale_en;

endpackage

// ===== rtl/core/hcd_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_scale
// Three-stage channel scaler: c * gain / 8355840, truncated and clamped.
// ----------------------------------------------------------------------------
module hcd_scale import hcd_pkg::*; (
    input  logic                     i_clk,
    input  t_scale_en                i_en,
    input  logic [7:0]               i_chan,
    input  logic signed [GAIN_W-1:0] i_gain,
    output logic [7:0]               o_chan
);

    logic [32:0]    w_prod;
    logic [32:0]    w_rcp;
    logic [15:0]    w_qa255;
    logic [16:0]    w_rem;
    logic           w_corr;

    logic [P_W-1:0] r_p;
    logic           r_pos_a;
    logic [15:0]    r_ph;
    logic [7:0]     r_qa;
    logic           r_clamp;
    logic           r_pos_b;
    logic [7:0]     r_chan;

    // stage 9: multiply and drop the power-of-two part of the denominator
    assign w_prod = 33'(i_chan) * 33'(i_gain[GAIN_W-2:0]);

    always_ff @(posedge i_clk) begin
        if (i_en.adv_mul) begin
            r_p     <= w_prod[GAIN_SH +: P_W];
            r_pos_a <= !i_gain[GAIN_W-1] && (i_gain != '0);
        end
    end

    // stage 10: estimate p / 255 by reciprocal, low by at most one
    assign w_rcp = 33'(r_p[15:0]) * 33'(D255_RCP);

    always_ff @(posedge i_clk) begin
        if (i_en.adv_div) begin
            r_qa    <= w_rcp[D255_SH +: 8];
            r_ph    <= r_p[15:0];
            r_clamp <= r_p >= P_W'(CH_CLAMP);
            r_pos_b <= r_pos_a;
        end
    end

    // stage 11: correct the estimate, clamp
    assign w_qa255 = {r_qa, 8'd0} - {8'd0, r_qa};
    assign w_rem   = {1'b0, r_ph} - {1'b0, w_qa255};
    assign w_corr  = w_rem >= 17'(CH_MAX);

    always_ff @(posedge i_clk) begin
        if (i_en.adv_out) begin
            if (!r_pos_b) begin
                r_chan <= '0;
            end else if (r_clamp) begin
                r_chan <= 8'(CH_MAX);
            end else begin
                r_chan <= r_qa + {7'd0, w_corr};
            end
        end
    end

    assign o_chan = r_chan;

endmodule

// ===== rtl/core/hex_cell_dither.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_cell_dither
// Hexagonal-cell brightness dither for a stream of RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one pixel: its x, y
//   position and red, green, blue bytes. A transfer happens on a rising edge
//   with valid high and stall low. Output channel (o_out_valid / i_out_stall)
//   carries one packed ARGB word per pixel, alpha always 0xFF.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the dither strength
//   (Q2.14); ready is always high. Write it only while the pipeline is empty.
//   o_out_valid rises once a pixel has passed through all 12 stages; one
//   pixel per cycle while the output is not stalled, and no shared unit.
//   Reset (synchronous, active low) empties every stage and loads the
//   strength with 2458 (about 0.15).
//   When the receiver stalls, the last stage holds its word; earlier stages
//   keep moving into empty slots, so input is stalled only once every stage
//   is full. Nothing is dropped or repeated.
// Stages: 0-3 cell q coordinate (divide by 433 via reciprocal), 4-5 r and s,
//   6 cube rounding, 7 largest-error fixup and hash byte, 8 gain,
//   9-11 per-channel scale and clamp.
// ----------------------------------------------------------------------------
`include "hex_cell_dither_defines.svh"

module hex_cell_dither import hcd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel input
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [POS_W-1:0]  i_x_position,
    input  logic [POS_W-1:0]  i_y_position,
    input  logic [7:0]        i_red_in,
    input  logic [7:0]        i_green_in,
    input  logic [7:0]        i_blue_in,
    // pixel output
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [31:0]       o_pixel_out,
    // strength register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data
);

    // Only the low COORD_BITS of a position count; the ports are POS_W wide.
    localparam int XW = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;

    function automatic t_round round_q16(input logic signed [CW-1:0] v);
        t_round     res;
        logic [CW-1:0] mag;
        logic [7:0] nlow;
        mag     = v[CW-1] ? CW'(-v) : CW'(v);
        nlow    = mag[23:16] + {7'd0, mag[15]};
        res.n8  = v[CW-1] ? 8'(-nlow) : nlow;
        res.err = mag[15] ? (ERR_W'(17'h10000) - {1'b0, mag[15:0]}) : {1'b0, mag[15:0]};
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Strength register
    // ------------------------------------------------------------------
    logic [15:0] r_strength;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= STRENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_strength <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage control: a stage advances when it is empty or the next one does
    // ------------------------------------------------------------------
    logic [NSTAGE-1:0] r_valid;
    logic [NSTAGE-1:0] stage_rdy;
    logic              in_xfer;
    logic              out_xfer;

    always_comb begin
        stage_rdy[NSTAGE-1] = !r_valid[NSTAGE-1] || !i_out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_rdy[k] = !r_valid[k] || stage_rdy[k+1];
        end
    end

    assign o_in_stall  = !stage_rdy[0];
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign o_out_valid = r_valid[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_rdy[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (stage_rdy[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Color shift line, stages 0..8
    // ------------------------------------------------------------------
    t_rgb r_rgb [9];

    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r_rgb[0] <= '{red: i_red_in, green: i_green_in, blue: i_blue_in};
        end
        for (int k = 1; k < 9; k++) begin
            if (stage_rdy[k]) begin
                r_rgb[k] <= r_rgb[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: split x * 2048000 / 433 into integer and fraction multiplies
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  w_x;
    logic [POS_W-1:0]  w_y;
    logic [BASE_W-1:0] r_s0_base;
    logic [T_W-1:0]    r_s0_t;
    logic [POS_W-1:0]  r_s0_y;

    assign w_x = POS_W'(i_x_position[XW-1:0]);
    assign w_y = POS_W'(i_y_position[XW-1:0]);

    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r_s0_base <= BASE_W'(w_x) * BASE_W'(Q_MUL_INT);
            r_s0_t    <= T_W'(w_x) * T_W'(Q_MUL_FRAC);
            r_s0_y    <= w_y;
        end
    end

    // Stage 1: reciprocal estimate of t / 433
    logic [T_W+16-1:0] w_trcp;
    logic [QA_W-1:0]   r_s1_qa;
    logic [T_W-1:0]    r_s1_t;
    logic [BASE_W-1:0] r_s1_base;
    logic [POS_W-1:0]  r_s1_y;

    assign w_trcp = (T_W+16)'(r_s0_t) * (T_W+16)'(Q_RCP);

    always_ff @(posedge i_clk) begin
        if (stage_rdy[1]) begin
            r_s1_qa   <= w_trcp[Q_RCP_SH +: QA_W];
            r_s1_t    <= r_s0_t;
            r_s1_base <= r_s0_base;
            r_s1_y    <= r_s0_y;
        end
    end

    // Stage 2: back-multiply the estimate
    logic [T_W-1:0]    r_s2_prod;
    logic [QA_W-1:0]   r_s2_qa;
    logic [T_W-1:0]    r_s2_t;
    logic [BASE_W-1:0] r_s2_base;
    logic [POS_W-1:0]  r_s2_y;

    always_ff @(posedge i_clk) begin
        if (stage_rdy[2]) begin
            r_s2_prod <= T_W'(r_s1_qa) * T_W'(Q_DIV);
            r_s2_qa   <= r_s1_qa;
            r_s2_t    <= r_s1_t;
            r_s2_base <= r_s1_base;
            r_s2_y    <= r_s1_y;
        end
    end

    // Stage 3: correct the estimate by one and assemble q
    logic [T_W-1:0]  w_rem;
    logic            w_corr;
    logic [QF_W-1:0] n_qf;
    logic [QF_W-1:0] r_s3_qf;
    logic [POS_W-1:0] r_s3_y;

    assign w_rem  = r_s2_t - r_s2_prod;
    assign w_corr = w_rem >= T_W'(Q_DIV);
    assign n_qf   = QF_W'(r_s2_base) + QF_W'(r_s2_qa) + QF_W'(w_corr);

    always_ff @(posedge i_clk) begin
        if (stage_rdy[3]) begin
            r_s3_qf <= n_qf;
            r_s3_y  <= r_s2_y;
        end
    end

    // Stage 4: r = y * 8192 - floor(q / 2)
    logic signed [CW-1:0] r_s4_qf;
    logic signed [CW-1:0] r_s4_rf;

    always_ff @(posedge i_clk) begin
        if (stage_rdy[4]) begin
            r_s4_qf <= $signed(CW'(r_s3_qf));
            r_s4_rf <= $signed({2'b00, r_s3_y, 13'd0}) - $signed(CW'(r_s3_qf[QF_W-1:1]));
        end
    end

    // Stage 5: s = -q - r
    logic signed [CW-1:0] r_s5_qf;
    logic signed [CW-1:0] r_s5_rf;
    logic signed [CW-1:0] r_s5_sf;

    always_ff @(posedge i_clk) begin
        if (stage_rdy[5]) begin
            r_s5_qf <= r_s4_qf;
            r_s5_rf <= r_s4_rf;
            r_s5_sf <= -r_s4_qf - r_s4_rf;
        end
    end

    // Stage 6: round each component half away from zero, keep its error.
    // Only the low byte of each rounded value reaches the hash.
    t_round r_s6_q;
    t_round r_s6_r;
    t_round r_s6_s;

    always_ff @(posedge i_clk) begin
        if (stage_rdy[6]) begin
            r_s6_q <= round_q16(r_s5_qf);
            r_s6_r <= round_q16(r_s5_rf);
            r_s6_s <= round_q16(r_s5_sf);
        end
    end

    // Stage 7: rebuild the component with the largest error, hash low byte
    logic [7:0]  w_iq;
    logic [7:0]  w_ir;
    logic [15:0] w_hq;
    logic [15:0] w_hr;
    logic [7:0]  n_b;
    logic [7:0]  r_s7_b;

    always_comb begin
        w_iq = r_s6_q.n8;
        w_ir = r_s6_r.n8;
        priority if (r_s6_q.err > r_s6_r.err && r_s6_q.err > r_s6_s.err) begin
            w_iq = 8'(-r_s6_r.n8 - r_s6_s.n8);
        end else if (r_s6_r.err > r_s6_s.err) begin
            w_ir = 8'(-r_s6_q.n8 - r_s6_s.n8);
        end
        w_hq = 16'(w_iq) * 16'(HASH_MUL_Q[7:0]);
        w_hr = 16'(w_ir) * 16'(HASH_MUL_R[7:0]);
        n_b  = w_hq[7:0] ^ w_hr[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[7]) begin
            r_s7_b <= n_b;
        end
    end

    // Stage 8: gain numerator 8355840 + (2b - 255) * strength
    logic signed [9:0]        w_dev;
    logic signed [CW-1:0]     w_gsum;
    logic signed [GAIN_W-1:0] n_gain;
    logic signed [GAIN_W-1:0] r_s8_gain;

    assign w_dev  = $signed({1'b0, r_s7_b, 1'b0}) - 10'sd255;
    assign w_gsum = $signed(CW'(GAIN_BASE)) + CW'(w_dev) * $signed(CW'(r_strength));
    assign n_gain = $signed(w_gsum[GAIN_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (stage_rdy[8]) begin
            r_s8_gain <= n_gain;
        end
    end

    // ------------------------------------------------------------------
    // Stages 9..11: one scaler per channel
    // ------------------------------------------------------------------
    t_scale_en  w_scale_en;
    logic [7:0] w_red;
    logic [7:0] w_green;
    logic [7:0] w_blue;

    assign w_scale_en = '{adv_mul: stage_rdy[9], adv_div: stage_rdy[10],
                          adv_out: stage_rdy[11]};

    hcd_scale u_scale_red (
        .i_clk  (i_clk),
        .i_en   (w_scale_en),
        .i_chan (r_rgb[8].red),
        .i_gain (r_s8_gain),
        .o_chan (w_red)
    );

    hcd_scale u_scale_green (
        .i_clk  (i_clk),
        .i_en   (w_scale_en),
        .i_chan (r_rgb[8].green),
        .i_gain (r_s8_gain),
        .o_chan (w_green)
    );

    hcd_scale u_scale_blue (
        .i_clk  (i_clk),
        .i_en   (w_scale_en),
        .i_chan (r_rgb[8].blue),
        .i_gain (r_s8_gain),
        .o_chan (w_blue)
    );

    assign o_pixel_out = {ALPHA, w_red, w_green, w_blue};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // input is held off only when every stage holds a pixel
    `HCD_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_in_stall, &r_valid)
    // pixels in flight change only by transfers at either end
    `HCD_ASSERT_IMPL(a_count_kept, i_clk, i_rst_n, $past(i_rst_n), $countones(r_valid) == $countones($past(r_valid)) + int'($past(in_xfer)) - int'($past(out_xfer)))
    // stage 4, when full and unable to advance, keeps its pixel
    `HCD_ASSERT_NEXT(a_mid_hold, i_clk, i_rst_n, r_valid[4] && !stage_rdy[4], r_valid[4])

endmodule

// ===== test/hcd_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_pixel_checker
// Watches the pixel, result and strength channels of hex_cell_dither. It
// predicts the dithered ARGB word of every pixel transfer and compares each
// result transfer, in order, with the oldest predicted word.
// ----------------------------------------------------------------------------
module hcd_pixel_checker import hcd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [POS_W-1:0] i_x_position,
    input  logic [POS_W-1:0] i_y_position,
    input  logic [7:0]       i_red_in,
    input  logic [7:0]       i_green_in,
    input  logic [7:0]       i_blue_in,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [31:0]      i_pixel_out,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_end_of_test,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_neg_gain,
    output int               o_saturated
);

    typedef struct {
        logic [31:0]      pixel;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_dithered_pixel;

    t_dithered_pixel dithered_q [$];
    logic [15:0]     strength_q14;
    int              fail_count     = 0;
    int              checked_count  = 0;
    int              neg_gain_count = 0;
    int              saturated      = 0;
    bit              leftovers_done = 1'b0;

    initial o_pending = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked_count;
    assign o_neg_gain   = neg_gain_count;
    assign o_saturated  = saturated;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Round a Q16 value half away from zero; err gets the exact rounding error.
    function automatic longint cube_round(input longint v, output longint err);
        longint mag;
        longint n;
        mag = (v < 0) ? -v : v;
        n   = (mag + 32768) >>> 16;
        if (v < 0)
            n = -n;
        err = n * 65536 - v;
        if (err < 0)
            err = -err;
        return n;
    endfunction

    function automatic logic [31:0] dither_pixel(
        input  logic [POS_W-1:0] x,
        input  logic [POS_W-1:0] y,
        input  t_rgb             px,
        input  logic [15:0]      strength,
        output bit               neg,
        output int               sat
    );
        longint      qf, rf, sf;
        longint      cq, cr, cs;
        longint      eq, er, es;
        longint      gain, lvl;
        logic [31:0] hash;
        logic [7:0]  level_in [3];
        logic [7:0]  level_out [3];
        level_in = '{px.red, px.green, px.blue};
        // axial coordinates: q = x / 13.856, r = y / 8 - q / 2, s = -q - r
        qf = (longint'(x) * 65536 * 125) / 1732;
        rf = longint'(y) * 8192 - qf / 2;
        sf = -qf - rf;
        cq = cube_round(qf, eq);
        cr = cube_round(rf, er);
        cs = cube_round(sf, es);
        // rebuild the component with strictly the largest error; ties keep q
        if (eq > er && eq > es)
            cq = -cr - cs;
        else if (er > es)
            cr = -cq - cs;
        hash = (32'(cq) * HASH_MUL_Q) ^ (32'(cr) * HASH_MUL_R);
        gain = longint'(GAIN_BASE) + (2 * longint'(hash[7:0]) - 255) * longint'(strength);
        neg  = (gain <= 0);
        sat  = 0;
        for (int c = 0; c < 3; c++) begin
            lvl = neg ? 0 : (longint'(level_in[c]) * gain) / longint'(GAIN_BASE);
            if (lvl > longint'(CH_MAX)) begin
                lvl = CH_MAX;
                sat++;
            end
            level_out[c] = lvl[7:0];
        end
        return {ALPHA, level_out[0], level_out[1], level_out[2]};
    endfunction

    always @(posedge i_clk) begin
        t_dithered_pixel want;
        bit              neg;
        int              sat;
        if (!i_rst_n) begin
            strength_q14 = STRENGTH_RESET;
            dithered_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                strength_q14 = i_cfg_data;

            // retire before predicting, so a result in the same cycle as its pixel is not masked
            if (i_out_valid && !i_out_stall) begin
                if (dithered_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel %08h", i_pixel_out));
                end else begin
                    want = dithered_q.pop_front();
                    checked_count++;
                    if (i_pixel_out !== want.pixel)
                        report_mismatch($sformatf("pixel (%0d,%0d): got %08h, want %08h",
                                                  want.x, want.y, i_pixel_out, want.pixel));
                end
            end

            if (i_in_valid && !i_in_stall) begin
                want.x     = i_x_position;
                want.y     = i_y_position;
                want.pixel = dither_pixel(i_x_position, i_y_position,
                                          '{i_red_in, i_green_in, i_blue_in},
                                          strength_q14, neg, sat);
                if (neg)
                    neg_gain_count++;
                saturated += sat;
                dithered_q.push_back(want);
            end

            if (i_end_of_test && !leftovers_done) begin
                leftovers_done = 1'b1;
                foreach (dithered_q[i])
                    report_mismatch($sformatf("pixel (%0d,%0d) never came out",
                                              dithered_q[i].x, dithered_q[i].y));
            end
        end
        o_pending <= dithered_q.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Pixel stream test of hex_cell_dither. Corner pixels and random pixels are
// pushed through the pipeline under eight dither strengths, from 0 to full
// scale, with random gaps on the sender and random stalls on the receiver.
// A separate checker predicts every ARGB word and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
    import hcd_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 203;
    localparam int MAX_WAIT        = 19;
    // pipeline is 12 deep; leave some margin before writes and at the end
    localparam int DRAIN_CYCLES    = 20;
    localparam int LONG_HOLD       = 80;
    localparam int IDLE_LIMIT      = 2000;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        t_rgb             px;
    } t_pixel_item;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             in_valid     = 1'b0;
    logic [POS_W-1:0] x_pos        = '0;
    logic [POS_W-1:0] y_pos        = '0;
    logic [7:0]       red          = '0;
    logic [7:0]       green        = '0;
    logic [7:0]       blue         = '0;
    logic             out_stall    = 1'b0;
    logic             cfg_valid    = 1'b0;
    logic [15:0]      cfg_data     = '0;
    logic             end_of_test  = 1'b0;
    logic             hold_output  = 1'b0;

    logic             o_in_stall;
    logic             o_out_valid;
    logic [31:0]      o_pixel_out;
    logic             o_cfg_ready;

    int               fail_count;
    int               pending;
    int               checked;
    int               neg_gain;
    int               saturated;
    int               pixels_sent  = 0;
    int               idle_cycles  = 0;

    logic [15:0]      strength_plan [PHASES-1];

    // Corners of the coordinate range, black and white, and cell centers and
    // edges along both axes. x = 0 makes the r and s errors tie.
    t_pixel_item corner_pixels [12] = '{
        '{12'd0,    12'd0,    '{8'd0,   8'd0,   8'd0}},
        '{12'd4095, 12'd4095, '{8'd255, 8'd255, 8'd255}},
        '{12'd0,    12'd4095, '{8'd255, 8'd0,   8'd128}},
        '{12'd4095, 12'd0,    '{8'd0,   8'd255, 8'd1}},
        '{12'd1,    12'd1,    '{8'd128, 8'd128, 8'd128}},
        '{12'd7,    12'd3,    '{8'd254, 8'd1,   8'd127}},
        '{12'd2048, 12'd2048, '{8'd85,  8'd170, 8'd255}},
        '{12'd14,   12'd0,    '{8'd255, 8'd255, 8'd255}},
        '{12'd0,    12'd8,    '{8'd255, 8'd255, 8'd255}},
        '{12'd13,   12'd7,    '{8'd200, 8'd100, 8'd50}},
        '{12'd2730, 12'd1365, '{8'd255, 8'd255, 8'd255}},
        '{12'd100,  12'd4000, '{8'd1,   8'd2,   8'd3}}
    };

    always #CLK_HALF clk = ~clk;

    hex_cell_dither DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_x_position (x_pos),
        .i_y_position (y_pos),
        .i_red_in     (red),
        .i_green_in   (green),
        .i_blue_in    (blue),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_pixel_out  (o_pixel_out),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    hcd_pixel_checker u_pixel_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (o_in_stall),
        .i_x_position  (x_pos),
        .i_y_position  (y_pos),
        .i_red_in      (red),
        .i_green_in    (green),
        .i_blue_in     (blue),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .i_pixel_out   (o_pixel_out),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_end_of_test (end_of_test),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_neg_gain    (neg_gain),
        .o_saturated   (saturated)
    );

    // Coordinates: mostly uniform, with the edges and the first few cells
    // weighted up so the rounding corner cases near the origin show up often.
    function automatic logic [POS_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return POS_W'($urandom_range(0, 31));
            default: return POS_W'($urandom);
        endcase
    endfunction

    // Channel levels: black and white weighted up to hit clamping at both ends.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one pixel after a random gap and hold it until the transfer.
    // Gaps vanish during the long output hold (to fill the pipeline) and in
    // every fourth stretch of 50 pixels.
    task automatic send_pixel(input t_pixel_item item);
        int unsigned gap;
        gap = (hold_output || (pixels_sent / 50) % 4 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_pos    <= item.x;
        y_pos    <= item.y;
        red      <= item.px.red;
        green    <= item.px.green;
        blue     <= item.px.blue;
        do @(posedge clk); while (o_in_stall);
        pixels_sent++;
    endtask

    // Drop valid and wait until every predicted pixel has come out. The
    // pending count is registered, so it falls to zero only after the last transfer.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Receiver: stall a random number of cycles before each result, with
    // stretches of no stalling, and one long hold when the sender asks.
    initial begin : receiver
        int unsigned wait_cycles;
        int          taken;
        bit          long_hold;
        taken = 0;
        @(posedge clk iff rst_n);
        forever begin
            long_hold = hold_output;
            if (long_hold)
                wait_cycles = LONG_HOLD;
            else if ((taken / 40) % 4 == 3)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, MAX_WAIT);
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            // release the sender only after the long hold was really taken
            if (long_hold)
                hold_output <= 1'b0;
            out_stall <= 1'b0;
            do @(posedge clk); while (!o_out_valid);
            taken++;
        end
    end

    // Watchdog: end the run when nothing transfers on any channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d pixels pending",
                     IDLE_LIMIT, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_pixel_item item;
        // Phase 0 runs with the reset strength; then zero, full scale, unity,
        // the smallest step, a random value, half scale and a mid value.
        strength_plan = '{16'd0, 16'hFFFF, 16'd16384, 16'd1,
                          16'($urandom_range(2, 65534)), 16'd32768, 16'd8191};
        @(posedge clk iff rst_n);
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                // write the strength only with the pipeline empty
                wait_drained();
                repeat (DRAIN_CYCLES) @(posedge clk);
                cfg_valid <= 1'b1;
                cfg_data  <= strength_plan[p-1];
                do @(posedge clk); while (!o_cfg_ready);
                cfg_valid <= 1'b0;
            end
            // corner pixels at the reset strength and at full scale, where
            // low hash bytes drive the gain negative
            if (p == 0 || p == 2)
                foreach (corner_pixels[i])
                    send_pixel(corner_pixels[i]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // pause the sender once until the pipeline has drained
                if (p == 0 && k == 100)
                    wait_drained();
                // hold the output long enough to back up into the input
                if ((p == 1 || p == 4) && k == 50)
                    hold_output <= 1'b1;
                item.x        = pick_coord();
                item.y        = pick_coord();
                item.px.red   = pick_level();
                item.px.green = pick_level();
                item.px.blue  = pick_level();
                send_pixel(item);
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);
        $display("Checked %0d dithered pixels across %0d strengths from 0 to 65535.",
                 checked, PHASES);
        $display("%0d pixels had a negative gain, %0d channels saturated at 255.",
                 neg_gain, saturated);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hcd_pkg.sv
rtl/core/hcd_scale.sv
rtl/core/hex_cell_dither.sv
test/hcd_pixel_checker.sv
test/tb.sv
